// File: sv/clas_pkg.sv
`timescale 1ns / 1ps
package clas_pkg;

   localparam int CHAR_W  = 16;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 8;
   localparam int RUN_W   = 6;

   // saturation limits
   localparam logic [RUN_W-1:0]   SLASH_LIMIT = RUN_W'(32);
   localparam logic [COUNT_W-1:0] ARG_LIMIT   = COUNT_W'(255);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ARG_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EOL     = 2'd2;

   // special characters
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_TAB       = 16'h0009;
   localparam logic [CHAR_W-1:0] CH_NUL       = 16'h0000;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit_slash;
      logic emit_t1;
      logic emit_t2;
      logic last;
   } clas_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dec_busy;
      logic slash_nz;
      logic slash_one;
      logic t1_v;
      logic t2_v;
   } clas_stat_type;

endpackage

// File: sv/clas_ctrl.sv
`timescale 1ns / 1ps
module clas_ctrl
   import clas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  clas_stat_type stat,
   output clas_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic emit_any;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign emit_any  = cmd.emit_slash || cmd.emit_t1 || cmd.emit_t2;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid && stat.dec_busy) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               priority if (stat.slash_nz) begin
                  cmd.emit_slash = 1'b1;
                  cmd.last       = stat.slash_one && !stat.t1_v && !stat.t2_v;
               end else if (stat.t1_v) begin
                  cmd.emit_t1 = 1'b1;
                  cmd.last    = !stat.t2_v;
               end else if (stat.t2_v) begin
                  cmd.emit_t2 = 1'b1;
                  cmd.last    = 1'b1;
               end else begin
                  cmd.last = 1'b1;
               end
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit_any) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_slash, cmd.emit_t1, cmd.emit_t2}))
      else $error("more than one emit command");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_any |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_any)
      else $error("emit while idle");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !stat.dec_busy) |=> (state_ff == ST_IDLE))
      else $error("empty item left controller busy");
`endif

endmodule

// File: sv/clas_dp.sv
`timescale 1ns / 1ps
module clas_dp
   import clas_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CHAR_W-1:0]  req_code_unit,
   input  clas_cmd_type       cmd,
   output clas_stat_type      stat,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [COUNT_W-1:0] rsp_arg_total,
   output logic               rsp_last_of_run
);

   // parsing state
   logic               quoted_ff, quoted_in;
   logic               inarg_ff, inarg_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               qpend_ff, qpend_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   // pending emission plan
   logic [RUN_W-1:0]   slash_left_ff;
   logic               t1_v_ff;
   logic [KIND_W-1:0]  t1_kind_ff;
   logic [CHAR_W-1:0]  t1_char_ff;
   logic [COUNT_W-1:0] t1_total_ff;
   logic               t2_v_ff;
   logic [COUNT_W-1:0] t2_total_ff;

   // decoded plan for the incoming item
   logic [RUN_W-1:0]   d_slash;
   logic               d_t1v;
   logic [KIND_W-1:0]  d_t1kind;
   logic [CHAR_W-1:0]  d_t1char;
   logic [COUNT_W-1:0] d_t1total;
   logic               d_t2v;
   logic [COUNT_W-1:0] d_t2total;

   // result register
   logic [CHAR_W-1:0]  out_char_ff;
   logic [KIND_W-1:0]  out_kind_ff;
   logic [COUNT_W-1:0] out_total_ff;
   logic               out_last_ff;

   logic is_quote, is_ws, is_zero, is_bslash;

   assign is_quote  = (req_code_unit == CH_QUOTE);
   assign is_ws     = (req_code_unit == CH_SPACE) || (req_code_unit == CH_TAB);
   assign is_zero   = (req_code_unit == CH_NUL);
   assign is_bslash = (req_code_unit == CH_BACKSLASH);

   always_comb begin
      quoted_in = quoted_ff;
      inarg_in  = inarg_ff;
      run_in    = run_ff;
      qpend_in  = qpend_ff;
      cnt_in    = cnt_ff;
      d_slash   = '0;
      d_t1v     = 1'b0;
      d_t1kind  = KIND_CHAR;
      d_t1char  = '0;
      d_t1total = '0;
      d_t2v     = 1'b0;
      d_t2total = '0;
      if (qpend_ff && is_quote) begin
         // doubled quote inside quotes
         qpend_in = 1'b0;
         d_t1v    = 1'b1;
         d_t1char = CH_QUOTE;
      end else begin
         if (qpend_ff) begin
            qpend_in  = 1'b0;
            quoted_in = 1'b0;
         end
         if (!inarg_ff && is_ws) begin
            d_t1v = 1'b0;
         end else if (!inarg_ff && is_zero) begin
            d_t1v     = 1'b1;
            d_t1kind  = KIND_EOL;
            d_t1total = cnt_ff;
            quoted_in = 1'b0;
            inarg_in  = 1'b0;
            run_in    = '0;
            qpend_in  = 1'b0;
            cnt_in    = '0;
         end else begin
            if (!inarg_ff) begin
               inarg_in = 1'b1;
               run_in   = '0;
               if (cnt_ff < ARG_LIMIT) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end
            priority if (is_bslash) begin
               if (run_in < SLASH_LIMIT) begin
                  run_in = run_in + RUN_W'(1);
               end
            end else if (is_quote) begin
               d_slash = run_in >> 1;
               if (!run_in[0]) begin
                  if (quoted_in) begin
                     qpend_in = 1'b1;
                  end else begin
                     quoted_in = 1'b1;
                  end
               end else begin
                  d_t1v    = 1'b1;
                  d_t1char = CH_QUOTE;
               end
               run_in = '0;
            end else if (is_zero) begin
               d_slash   = run_in;
               d_t1v     = 1'b1;
               d_t1kind  = KIND_ARG_END;
               d_t2v     = 1'b1;
               d_t2total = cnt_in;
               quoted_in = 1'b0;
               inarg_in  = 1'b0;
               run_in    = '0;
               qpend_in  = 1'b0;
               cnt_in    = '0;
            end else if (is_ws && !quoted_in) begin
               d_slash  = run_in;
               d_t1v    = 1'b1;
               d_t1kind = KIND_ARG_END;
               run_in   = '0;
               inarg_in = 1'b0;
            end else begin
               d_slash  = run_in;
               d_t1v    = 1'b1;
               d_t1char = req_code_unit;
               run_in   = '0;
            end
         end
      end
   end

   assign stat.dec_busy  = (d_slash != '0) || d_t1v || d_t2v;
   assign stat.slash_nz  = (slash_left_ff != '0);
   assign stat.slash_one = (slash_left_ff == RUN_W'(1));
   assign stat.t1_v      = t1_v_ff;
   assign stat.t2_v      = t2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff     <= 1'b0;
         inarg_ff      <= 1'b0;
         run_ff        <= '0;
         qpend_ff      <= 1'b0;
         cnt_ff        <= '0;
         slash_left_ff <= '0;
         t1_v_ff       <= 1'b0;
         t2_v_ff       <= 1'b0;
      end else begin
         if (cmd.load) begin
            quoted_ff     <= quoted_in;
            inarg_ff      <= inarg_in;
            run_ff        <= run_in;
            qpend_ff      <= qpend_in;
            cnt_ff        <= cnt_in;
            slash_left_ff <= d_slash;
            t1_v_ff       <= d_t1v;
            t2_v_ff       <= d_t2v;
         end else begin
            if (cmd.emit_slash) begin
               slash_left_ff <= slash_left_ff - RUN_W'(1);
            end
            if (cmd.emit_t1) begin
               t1_v_ff <= 1'b0;
            end
            if (cmd.emit_t2) begin
               t2_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t1_kind_ff  <= d_t1kind;
         t1_char_ff  <= d_t1char;
         t1_total_ff <= d_t1total;
         t2_total_ff <= d_t2total;
      end
      if (cmd.emit_slash) begin
         out_char_ff  <= CH_BACKSLASH;
         out_kind_ff  <= KIND_CHAR;
         out_total_ff <= '0;
         out_last_ff  <= cmd.last;
      end else if (cmd.emit_t1) begin
         out_char_ff  <= t1_char_ff;
         out_kind_ff  <= t1_kind_ff;
         out_total_ff <= t1_total_ff;
         out_last_ff  <= cmd.last;
      end else if (cmd.emit_t2) begin
         out_char_ff  <= CH_NUL;
         out_kind_ff  <= KIND_EOL;
         out_total_ff <= t2_total_ff;
         out_last_ff  <= cmd.last;
      end
   end

   assign rsp_out_char    = out_char_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_arg_total   = out_total_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

// File: sv/command_line_argument_splitter.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_code_unit[15:0]
// rsp     | out       | rsp_valid/rsp_stall  | rsp_out_char, rsp_kind, rsp_arg_total,
//         |           |                      | rsp_last_of_run
//
// an item with no result (blank, backslash, plain opening quote) leaves req_stall low
// an item with n results is decoded when taken, then its results go out one at a time
// from the single result register, in the order the emission sequencer walks them
// reset is synchronous and returns the parser to the start of a line
// rsp_stall holds the result register and pauses the sequencer; req_stall is
// high while a decoded item still has results to send
module command_line_argument_splitter
   import clas_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CHAR_W-1:0]  req_code_unit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [COUNT_W-1:0] rsp_arg_total,
   output logic               rsp_last_of_run
);

   // commands from the sequencer, plan status from the parser
   clas_cmd_type  cmd;
   clas_stat_type stat;

   // sequencer: takes an item, then walks backslashes, first tail, second tail
   clas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // parser state, decoded emission plan and result register
   clas_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_code_unit   (req_code_unit),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_out_char    (rsp_out_char),
      .rsp_kind        (rsp_kind),
      .rsp_arg_total   (rsp_arg_total),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: dv/tb_command_line_argument_splitter.sv
`timescale 1ns / 1ps
import clas_pkg::*;

typedef struct packed {
   logic [CHAR_W-1:0]  out_char;
   logic [KIND_W-1:0]  kind;
   logic [COUNT_W-1:0] arg_total;
   logic               last_of_run;
} split_result_type;

class splitter_scoreboard;
   // parser state mirrored from the block
   bit                 quoted;
   bit                 in_arg;
   bit                 quote_pending;
   logic [RUN_W-1:0]   slash_run;
   logic [COUNT_W-1:0] arg_count;

   split_result_type expected_results[$];

   int errors;
   int chars_taken;
   int results_checked;
   int lines_ended;
   int slash_saturations;
   int arg_saturations;

   function new();
      clear_line();
   endfunction

   function void clear_line();
      quoted        = 1'b0;
      in_arg        = 1'b0;
      quote_pending = 1'b0;
      slash_run     = '0;
      arg_count     = '0;
   endfunction

   function void push_result(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                             logic [COUNT_W-1:0] total);
      split_result_type r;
      r.out_char    = ch;
      r.kind        = kind;
      r.arg_total   = total;
      r.last_of_run = 1'b0;
      expected_results.push_back(r);
      if (kind == KIND_EOL) lines_ended++;
   endfunction

   function void push_slashes(int unsigned count);
      for (int unsigned k = 0; k < count; k++) push_result(KIND_CHAR, CH_BACKSLASH, '0);
   endfunction

   // flag the final result caused by one character
   function void mark_last(int unsigned base_n);
      split_result_type r;
      if (expected_results.size() > base_n) begin
         r = expected_results.pop_back();
         r.last_of_run = 1'b1;
         expected_results.push_back(r);
      end
   endfunction

   // predicts the results of one accepted character
   function void note_char(logic [CHAR_W-1:0] c);
      bit               blank;
      int unsigned      base_n;
      logic [RUN_W-1:0] run;
      blank   = (c == CH_SPACE) || (c == CH_TAB);
      base_n  = expected_results.size();
      chars_taken++;

      if (quote_pending) begin
         quote_pending = 1'b0;
         if (c == CH_QUOTE) begin
            push_result(KIND_CHAR, CH_QUOTE, '0);
            mark_last(base_n);
            return;
         end
         quoted = 1'b0;
      end

      if (!in_arg) begin
         if (blank) return;
         if (c == CH_NUL) begin
            push_result(KIND_EOL, '0, arg_count);
            clear_line();
            mark_last(base_n);
            return;
         end
         in_arg    = 1'b1;
         slash_run = '0;
         if (arg_count < ARG_LIMIT) arg_count++;
         else arg_saturations++;
      end

      if (c == CH_BACKSLASH) begin
         if (slash_run < SLASH_LIMIT) slash_run++;
         else slash_saturations++;
         return;
      end

      if (c == CH_QUOTE) begin
         run       = slash_run;
         slash_run = '0;
         push_slashes(run >> 1);
         if (!run[0]) begin
            if (quoted) quote_pending = 1'b1;
            else quoted = 1'b1;
         end else begin
            push_result(KIND_CHAR, CH_QUOTE, '0);
         end
      end else if (c == CH_NUL) begin
         push_slashes(slash_run);
         push_result(KIND_ARG_END, '0, '0);
         push_result(KIND_EOL, '0, arg_count);
         clear_line();
      end else if (blank && !quoted) begin
         push_slashes(slash_run);
         push_result(KIND_ARG_END, '0, '0);
         slash_run = '0;
         in_arg    = 1'b0;
      end else begin
         push_slashes(slash_run);
         push_result(KIND_CHAR, c, '0);
         slash_run = '0;
      end

      mark_last(base_n);
   endfunction

   function void check_result(logic [CHAR_W-1:0] ch, logic [KIND_W-1:0] kind,
                              logic [COUNT_W-1:0] total, logic last);
      split_result_type e;
      if (expected_results.size() == 0) begin
         $error("unexpected result: out_char %h kind %0d arg_total %0d last_of_run %0b",
                ch, kind, total, last);
         errors++;
         return;
      end
      e = expected_results.pop_front();
      results_checked++;
      if (ch !== e.out_char) begin
         $error("out_char mismatch: expected %h, got %h", e.out_char, ch);
         errors++;
      end
      if (kind !== e.kind) begin
         $error("kind mismatch: expected %0d, got %0d", e.kind, kind);
         errors++;
      end
      if (total !== e.arg_total) begin
         $error("arg_total mismatch: expected %0d, got %0d", e.arg_total, total);
         errors++;
      end
      if (last !== e.last_of_run) begin
         $error("last_of_run mismatch: expected %0b, got %0b", e.last_of_run, last);
         errors++;
      end
   endfunction
endclass

module tb_command_line_argument_splitter;

   // cycles with no handshake on either channel before the run is abandoned;
   // the longest quiet stretch is a receiver stall or a sender gap, both far shorter
   localparam int IDLE_LIMIT   = 4000;
   // an item yields at most 34 results: a saturated backslash run and two tails
   localparam int DRAIN_CYCLES = 60;
   // random part stops once this many characters in all were accepted
   localparam int ITEM_TARGET  = 460;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CHAR_W-1:0]  req_code_unit = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAR_W-1:0]  rsp_out_char;
   logic [KIND_W-1:0]  rsp_kind;
   logic [COUNT_W-1:0] rsp_arg_total;
   logic               rsp_last_of_run;

   splitter_scoreboard sb;

   int burst_left    = 0;
   int idle_cycles   = 0;
   int stall_mode    = 0;
   int stall_left    = 0;
   int stall_phase   = 0;

   command_line_argument_splitter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_kind        (rsp_kind),
      .rsp_arg_total   (rsp_arg_total),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // sender: items go out in bursts, with a random gap before each burst;
   // valid is only lowered when a gap really follows, so a burst keeps it high
   task automatic send_item(logic [CHAR_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) == 0) gap = 0;
         else if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 40);
         else gap = $urandom_range(1, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_code_unit <= c;
      // wait for the edge where the block takes the item
      do @(posedge clock); while (req_stall);
      sb.note_char(c);
   endtask

   // any character that has no special meaning to the splitter
   function automatic logic [CHAR_W-1:0] pick_plain();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(1, 16'hFFFF));
      if (c == CH_BACKSLASH || c == CH_QUOTE || c == CH_SPACE || c == CH_TAB) c = 16'h0061;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_blank();
      return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
   endfunction

   // noise leans on the special characters, zero included
   function automatic logic [CHAR_W-1:0] pick_any();
      case ($urandom_range(0, 7))
         0: return CH_NUL;
         1: return CH_BACKSLASH;
         2: return CH_QUOTE;
         3: return CH_SPACE;
         4: return CH_TAB;
         default: return CHAR_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // one well formed line: blanks, a few arguments built from random pieces, a zero
   task automatic send_line();
      int n_args;
      int n_pieces;
      int len;
      n_args = $urandom_range(0, 5);
      repeat ($urandom_range(0, 2)) send_item(pick_blank());
      for (int a = 0; a < n_args; a++) begin
         n_pieces = $urandom_range(1, 5);
         for (int p = 0; p < n_pieces; p++) begin
            case ($urandom_range(0, 7))
               0, 1, 2, 3: send_item(pick_plain());
               4: begin
                  // now and then a run near or past the backslash ceiling
                  len = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 40)
                                                     : $urandom_range(1, 4);
                  repeat (len) send_item(CH_BACKSLASH);
               end
               5: send_item(CH_QUOTE);
               6: begin
                  // doubled quote, literal when already quoted
                  send_item(CH_QUOTE);
                  send_item(CH_QUOTE);
               end
               default: send_item(pick_blank());
            endcase
         end
         // separator between arguments, sometimes trailing blanks before the zero
         if (a < n_args - 1 || $urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 2)) send_item(pick_blank());
      end
      send_item(CH_NUL);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) send_item(pick_any());
   endtask

   // stimulus and end of run
   initial begin
      logic [CHAR_W-1:0] directed_chars[$];
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed_chars = '{
         // blanks before anything, then an empty line
         CH_SPACE, CH_TAB, CH_NUL,
         // extreme characters, argument closed by a tab
         16'hFFFF, 16'h0001, CH_TAB,
         // quoted blank, doubled quote, pending quote closed by a plain char
         CH_QUOTE, CH_SPACE, CH_QUOTE, CH_QUOTE, CH_QUOTE, 16'h0062, CH_SPACE,
         // even run before a quote, odd run before a quote, zero inside an argument
         CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE,
         CH_BACKSLASH, CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE,
         CH_BACKSLASH, CH_NUL,
         // pending quote followed by the zero
         16'h0078, CH_QUOTE, 16'h0061, CH_QUOTE, CH_NUL
      };
      foreach (directed_chars[i]) send_item(directed_chars[i]);

      // random part: mostly proper lines, some noise
      while (sb.chars_taken < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_line();
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d characters, checked %0d results over %0d lines",
               sb.chars_taken, sb.results_checked, sb.lines_ended);
      $display("ceilings hit: %0d backslashes dropped, %0d arguments past the count limit",
               sb.slash_saturations, sb.arg_saturations);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver: stall pattern switches among free running, light, heavy and periodic
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase % 3 == 0);
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_char, rsp_kind, rsp_arg_total, rsp_last_of_run);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results still expected",
                  idle_cycles, sb.expected_results.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
